[rtl/vrg_pkg.sv]
// ----------------------------------------------------------------------------
// vrg_pkg
// Shared types and constants of the version refcount gate.
// ----------------------------------------------------------------------------
package vrg_pkg;

  localparam int FIELD_W = 8;   // width of index fields on the channels
  localparam int OUTER_W = 16;  // outer acquire count, wraps
  localparam int INNER_W = 18;  // inner counters, signed, wrap

  typedef enum logic [1:0] {
    REQ_ACQUIRE = 2'd0,
    REQ_RELEASE = 2'd1,
    REQ_SWAP    = 2'd2,
    REQ_CAS     = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_IN_USE     = 2'd0,
    STS_SAFE_FREE  = 2'd1,
    STS_CMP_FAIL   = 2'd2,
    STS_NO_VERSION = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } ctrl_state_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_index;
    status_t            status;
  } result_t;

endpackage

[rtl/vrg_if.sv]
// ----------------------------------------------------------------------------
// vrg_if
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vrg_in_if import vrg_pkg::*; ();
  logic               valid;
  logic               ready;
  req_t               req_type;
  logic [FIELD_W-1:0] version_index;
  logic [FIELD_W-1:0] expected_index;

  modport source (output valid, req_type, version_index, expected_index, input ready);
  modport sink   (input valid, req_type, version_index, expected_index, output ready);
endinterface

interface vrg_out_if import vrg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] result_index;
  status_t            status;

  modport source (output valid, result_index, status, input ready);
  modport sink   (input valid, result_index, status, output ready);
endinterface

[rtl/vrg_mem.sv]
// ----------------------------------------------------------------------------
// vrg_mem
// Inner counter table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module vrg_mem import vrg_pkg::*; #(
  parameter int AW = 8
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [INNER_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [AW-1:0]      rd_addr,
  output logic [INNER_W-1:0] rd_data
);

  localparam int DEPTH = 1 << AW;

  logic [INNER_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/vrg_obuf.sv]
// ----------------------------------------------------------------------------
// vrg_obuf
// Result register with one skid entry so requests keep flowing while a
// result waits.
// ----------------------------------------------------------------------------
module vrg_obuf import vrg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  result_t   push_data,
  output logic      free,
  vrg_out_if.source out_ch
);

  logic    out_v_r, out_v_nxt;
  result_t out_d_r, out_d_nxt;
  logic    sk_v_r, sk_v_nxt;
  result_t sk_d_r, sk_d_nxt;
  logic    drain;

  assign drain = !out_v_r || out_ch.ready;
  assign free  = !sk_v_r;

  always_comb begin
    out_v_nxt = out_v_r;
    out_d_nxt = out_d_r;
    sk_v_nxt  = sk_v_r;
    sk_d_nxt  = sk_d_r;
    if (drain) begin
      if (sk_v_r) begin
        out_v_nxt = 1'b1;
        out_d_nxt = sk_d_r;
        sk_v_nxt  = 1'b0;
      end else begin
        out_v_nxt = push;
        out_d_nxt = push_data;
      end
    end else if (push) begin
      sk_v_nxt = 1'b1;
      sk_d_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      sk_v_r  <= sk_v_nxt;
    end
    out_d_r <= out_d_nxt;
    sk_d_r  <= sk_d_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.result_index = out_d_r.result_index;
  assign out_ch.status       = out_d_r.status;

endmodule

[rtl/vrg_ctrl.sv]
// ----------------------------------------------------------------------------
// vrg_ctrl
// Request sequencer: holds current index and outer count, drives the
// counter table clearing pass, read and write-back, and forms each result.
// ----------------------------------------------------------------------------
module vrg_ctrl import vrg_pkg::*; #(
  parameter int IW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  vrg_in_if.sink             in_ch,
  input  logic               obuf_free,
  output logic               res_push,
  output result_t            res_data,
  output logic               mem_wr_en,
  output logic [IW-1:0]      mem_wr_addr,
  output logic [INNER_W-1:0] mem_wr_data,
  output logic               mem_rd_en,
  output logic [IW-1:0]      mem_rd_addr,
  input  logic [INNER_W-1:0] mem_rd_data
);

  ctrl_state_t        state_r, state_nxt;
  logic [IW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [IW-1:0]      cur_idx_r, cur_idx_nxt;
  logic [OUTER_W-1:0] outer_r, outer_nxt;
  req_t               op_r;
  logic [IW-1:0]      op_idx_r;
  logic               cmp_fail_r;

  logic               accept;
  logic [IW-1:0]      in_vidx;
  logic [IW-1:0]      in_eidx;
  logic [INNER_W-1:0] cnt_new;

  assign in_vidx = IW'(in_ch.version_index);
  assign in_eidx = IW'(in_ch.expected_index);

  assign in_ch.ready = (state_r == ST_IDLE) && obuf_free;
  assign accept      = in_ch.valid && in_ch.ready;

  // table read is issued on the accept edge
  assign mem_rd_en   = accept;
  assign mem_rd_addr = (in_ch.req_type == REQ_RELEASE) ? in_vidx : cur_idx_r;

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cur_idx_nxt  = cur_idx_r;
    outer_nxt    = outer_r;
    res_push     = 1'b0;
    res_data     = '{result_index: FIELD_W'(cur_idx_r), status: STS_IN_USE};
    mem_wr_en    = 1'b0;
    mem_wr_addr  = cur_idx_r;
    mem_wr_data  = '0;
    cnt_new      = mem_rd_data - INNER_W'(outer_r);
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en    = 1'b1;
        mem_wr_addr  = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_push  = 1'b1;
        state_nxt = ST_IDLE;
        case (op_r)
          REQ_ACQUIRE: begin
            outer_nxt = outer_r + 1'b1;
            if (cur_idx_r == '0) begin
              res_data.status = STS_NO_VERSION;
            end
          end
          REQ_RELEASE: begin
            res_data.result_index = FIELD_W'(op_idx_r);
            cnt_new               = mem_rd_data + 1'b1;
            if (op_idx_r == '0) begin
              res_data.status = STS_NO_VERSION;
            end else begin
              mem_wr_en       = 1'b1;
              mem_wr_addr     = op_idx_r;
              mem_wr_data     = cnt_new;
              res_data.status = (cnt_new == '0) ? STS_SAFE_FREE : STS_IN_USE;
            end
          end
          default: begin
            // swap, or compare and swap
            if (op_r == REQ_CAS && cmp_fail_r) begin
              res_data.status = STS_CMP_FAIL;
            end else begin
              cur_idx_nxt = op_idx_r;
              outer_nxt   = '0;
              if (cur_idx_r == '0) begin
                res_data.status = STS_NO_VERSION;
              end else begin
                mem_wr_en       = 1'b1;
                mem_wr_data     = cnt_new;
                res_data.status = (cnt_new == '0) ? STS_SAFE_FREE : STS_IN_USE;
              end
            end
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      cur_idx_r  <= '0;
      outer_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cur_idx_r  <= cur_idx_nxt;
      outer_r    <= outer_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_ch.req_type;
      op_idx_r   <= in_vidx;
      cmp_fail_r <= (in_eidx != cur_idx_r);
    end
  end

endmodule

[rtl/version_refcount_gate.sv]
// ----------------------------------------------------------------------------
// version_refcount_gate
// Split reference count version gate with a table of inner counters.
// ----------------------------------------------------------------------------
// result: a request passes the execute state, then the result register of the
//   output stage, before its result is valid on the output channel
// intake: ready only in the idle state with a free skid entry, so a new request
//   waits until the previous one has done its counter table read and write-back
// reset: synchronous, active low; current index and outer count go to zero,
//   then a clearing pass zeroes all 2^INDEX_BITS table entries, in ready low
module version_refcount_gate import vrg_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  vrg_in_if.sink    in_ch,
  vrg_out_if.source out_ch
);

  // table port signals
  logic               mem_wr_en;
  logic [INDEX_BITS-1:0] mem_wr_addr;
  logic [INNER_W-1:0] mem_wr_data;
  logic               mem_rd_en;
  logic [INDEX_BITS-1:0] mem_rd_addr;
  logic [INNER_W-1:0] mem_rd_data;

  // result hand-off to the output stage
  logic    res_push;
  result_t res_data;
  logic    obuf_free;

  // sequencer: accepts a request, reads the counter, writes it back next cycle on release or swap
  vrg_ctrl #(
    .IW (INDEX_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .obuf_free   (obuf_free),
    .res_push    (res_push),
    .res_data    (res_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  // inner counter table, one entry per version index
  vrg_mem #(
    .AW (INDEX_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // output register plus skid entry, keeps intake open while a result waits
  vrg_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .free      (obuf_free),
    .out_ch    (out_ch)
  );

endmodule
